// ----- sv/stok_pkg.sv -----
// ============================================================================
// Source tokenizer package
// Shared types, kind codes, scan modes and the keyword lookup.
// ============================================================================
`default_nettype none

package stok_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LN_MAX  = {LINE_BITS{1'b1}};

    // scan modes
    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_IDENT      = 4'd1;
    localparam logic [3:0] M_NUM_ZERO   = 4'd2;
    localparam logic [3:0] M_NUM        = 4'd3;
    localparam logic [3:0] M_SLASH      = 4'd4;
    localparam logic [3:0] M_LINE       = 4'd5;
    localparam logic [3:0] M_BLOCK      = 4'd6;
    localparam logic [3:0] M_BLOCK_STAR = 4'd7;
    localparam logic [3:0] M_MINUS      = 4'd8;
    localparam logic [3:0] M_BANG       = 4'd9;
    localparam logic [3:0] M_ASSIGN     = 4'd10;
    localparam logic [3:0] M_LESS       = 4'd11;
    localparam logic [3:0] M_GREATER    = 4'd12;

    // token kinds
    localparam logic [5:0] K_ERROR  = 6'd0;
    localparam logic [5:0] K_EOF    = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_INT    = 6'd3;
    localparam logic [5:0] K_LPAREN = 6'd22;
    localparam logic [5:0] K_RPAREN = 6'd23;
    localparam logic [5:0] K_LBRACE = 6'd24;
    localparam logic [5:0] K_RBRACE = 6'd25;
    localparam logic [5:0] K_COLON  = 6'd26;
    localparam logic [5:0] K_COMMA  = 6'd27;
    localparam logic [5:0] K_SEMI   = 6'd28;
    localparam logic [5:0] K_PLUS   = 6'd29;
    localparam logic [5:0] K_MINUS  = 6'd30;
    localparam logic [5:0] K_STAR   = 6'd31;
    localparam logic [5:0] K_SLASH  = 6'd32;
    localparam logic [5:0] K_PCT    = 6'd33;
    localparam logic [5:0] K_BANG   = 6'd34;
    localparam logic [5:0] K_ASSIGN = 6'd35;
    localparam logic [5:0] K_EQ     = 6'd36;
    localparam logic [5:0] K_NE     = 6'd37;
    localparam logic [5:0] K_LT     = 6'd38;
    localparam logic [5:0] K_LE     = 6'd39;
    localparam logic [5:0] K_GT     = 6'd40;
    localparam logic [5:0] K_GE     = 6'd41;
    localparam logic [5:0] K_ARROW  = 6'd42;
    localparam logic [5:0] K_AMP    = 6'd44;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_BLOCK = 2'd1;
    localparam logic [1:0] E_INT   = 2'd2;
    localparam logic [1:0] E_CHAR  = 2'd3;

    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_HEX = 2'd1;
    localparam logic [1:0] B_BIN = 2'd2;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
        logic [1:0]             err;
        logic [15:0]            errs;
        logic                   fin;
    } token_t;

    typedef struct packed {
        logic   n1;
        logic   n2;
        token_t t1;
        token_t t2;
    } result_t;

    // keyword lookup over the last six bytes of a word
    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        unique case (n)
            3'd2:
            begin
                priority case (w[15:0])
                    "fn": k = 6'd4;
                    "if": k = 6'd7;
                    "i8": k = 6'd13;
                    "u8": k = 6'd17;
                    default: k = K_IDENT;
                endcase
            end
            3'd3:
            begin
                priority case (w[23:0])
                    "let": k = 6'd5;
                    "for": k = 6'd10;
                    "i16": k = 6'd14;
                    "i32": k = 6'd15;
                    "i64": k = 6'd16;
                    "u16": k = 6'd18;
                    "u32": k = 6'd19;
                    "u64": k = 6'd20;
                    "ref": k = 6'd43;
                    default: k = K_IDENT;
                endcase
            end
            3'd4:
            begin
                priority case (w[31:0])
                    "else": k = 6'd8;
                    "true": k = 6'd11;
                    "bool": k = 6'd21;
                    default: k = K_IDENT;
                endcase
            end
            3'd5:
            begin
                priority case (w[39:0])
                    "while": k = 6'd9;
                    "false": k = 6'd12;
                    default: k = K_IDENT;
                endcase
            end
            3'd6:
            begin
                if (w == "return")
                begin
                    k = 6'd6;
                end
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/source_tokenizer_top.sv -----
// ============================================================================
// Source tokenizer top level
// Byte stream in, token stream out, one byte per cycle while the queue has room.
// ============================================================================
//
//  channel  | dir | tdata (low bit first)                      | tuser / tlast
//  s_axis   | in  | source_byte[7:0]                           | tuser: operation
//  m_axis   | out | token_kind, start_offset, token_length,    | tlast: final_token
//           |     | start_line, start_column, error_code,      |
//           |     | errors_so_far (136 bits)                   |
//
// One source byte is taken per cycle while the queue has room; its tokens are
// known in the same cycle from the scan state and are written into a four-entry queue.
// A request may give up to two tokens, so the input is held off while the
// queue holds more than two, which is the only back-pressure path.
// Reset clears scan state, offset, error count and queue pointers; line and column go to 1.
// Tokens leave in order, one per cycle while m_axis_tready is high.
`default_nettype none

module source_tokenizer_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // source_byte
    input  wire logic         s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,   // kind, offset, length, line, column, error, count
    output logic              m_axis_tlast    // final_token
);
    import stok_pkg::*;

    result_t res;
    token_t  head;
    logic    room;

    assign s_axis_tready = room;

    stok_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s_axis_tvalid && room),
        .op    (s_axis_tuser),
        .b     (s_axis_tdata),
        .res   (res)
    );

    stok_outq u_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .room  (room),
        .valid (m_axis_tvalid),
        .take  (m_axis_tready),
        .head  (head)
    );

    assign m_axis_tdata = {head.errs, head.err, head.col, head.line,
                           head.len, head.start, head.kind};
    assign m_axis_tlast = head.fin;

endmodule

`default_nettype wire

// ----- sv/stok_scan.sv -----
// ============================================================================
// Tokenizer scan step
// Holds the scan state and turns one input byte into up to two tokens.
// ============================================================================
`default_nettype none

module stok_scan
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              op,
    input  wire logic [7:0]        b,
    output stok_pkg::result_t      res
);
    import stok_pkg::*;

    logic [3:0]             mode_reg, mode_next;
    logic                   crp_reg, crp_next;
    logic [47:0]            kw_reg, kw_next;
    logic [2:0]             wl_reg, wl_next;
    logic [1:0]             base_reg, base_next;
    logic [2:0]             fl_reg, fl_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [OFFSET_BITS-1:0] tsp_reg, tsp_next;
    logic [LINE_BITS-1:0]   tsl_reg, tsl_next;
    logic [LINE_BITS-1:0]   tsc_reg, tsc_next;
    logic [15:0]            et_reg;
    logic                   closed_reg, closed_next;

    logic is_start, is_digit, is_cont, is_brk, is_bad_digit;
    logic [4:0] dig;
    logic [OFFSET_BITS-1:0] pos_inc, len_pend;
    logic [LINE_BITS-1:0] line_inc, col_inc;
    logic [5:0] wk;
    logic num_bad;
    logic [1:0] ecount;
    logic [5:0] k1, k2;
    logic [OFFSET_BITS-1:0] l1, l2;
    logic [1:0] e1, e2;
    logic p1, p2, fin2;
    logic do_start, do_move;
    logic [5:0] one_kind;
    logic [7:0] op_second;
    logic [5:0] op_two, op_one;
    logic [15:0] et1, et2;

    always_comb
    begin
        is_start = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
        is_digit = b >= "0" && b <= "9";
        is_cont  = is_start || is_digit;
        is_brk   = b == CH_CR || b == CH_LF;
        if (is_digit) dig = {1'b0, b[3:0]};
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            dig = 5'd9 + {2'b0, b[2:0]};
        else dig = 5'd16;
        unique case (base_reg)
            B_HEX:   is_bad_digit = dig >= 5'd16;
            B_BIN:   is_bad_digit = dig >= 5'd2;
            default: is_bad_digit = dig >= 5'd10;
        endcase
        pos_inc  = (pos_reg != OFF_MAX) ? pos_reg + 1'b1 : pos_reg;
        line_inc = (line_reg != LN_MAX) ? line_reg + 1'b1 : line_reg;
        col_inc  = (col_reg != LN_MAX) ? col_reg + 1'b1 : col_reg;
        len_pend = pos_reg - tsp_reg;
        wk = word_kind(kw_reg, wl_reg);
        num_bad = !fl_reg[0] || fl_reg[1] || fl_reg[2];
        unique case (mode_reg)
            M_MINUS:  begin op_second = ">"; op_two = K_ARROW; op_one = K_MINUS;  end
            M_BANG:   begin op_second = "="; op_two = K_NE;    op_one = K_BANG;   end
            M_ASSIGN: begin op_second = "="; op_two = K_EQ;    op_one = K_ASSIGN; end
            M_LESS:   begin op_second = "="; op_two = K_LE;    op_one = K_LT;     end
            default:  begin op_second = "="; op_two = K_GE;    op_one = K_GT;     end
        endcase
        unique case (b)
            "(": one_kind = K_LPAREN;
            ")": one_kind = K_RPAREN;
            "{": one_kind = K_LBRACE;
            "}": one_kind = K_RBRACE;
            ":": one_kind = K_COLON;
            ",": one_kind = K_COMMA;
            ";": one_kind = K_SEMI;
            "+": one_kind = K_PLUS;
            "*": one_kind = K_STAR;
            "%": one_kind = K_PCT;
            "&": one_kind = K_AMP;
            default: one_kind = K_ERROR;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg; crp_next = crp_reg; kw_next = kw_reg; wl_next = wl_reg;
        base_next = base_reg; fl_next = fl_reg; pos_next = pos_reg;
        line_next = line_reg; col_next = col_reg; tsp_next = tsp_reg;
        tsl_next = tsl_reg; tsc_next = tsc_reg; closed_next = closed_reg;
        p1 = 1'b0; p2 = 1'b0; k1 = K_ERROR; k2 = K_ERROR; l1 = '0; l2 = '0;
        e1 = E_NONE; e2 = E_NONE; fin2 = 1'b0; ecount = 2'd0;
        do_start = 1'b0; do_move = 1'b0;
        if (step && !closed_reg)
        begin
            if (op || b == 8'd0)
            begin
                priority if (mode_reg == M_IDENT)
                begin
                    p1 = 1'b1; k1 = wk; l1 = len_pend;
                end
                else if (mode_reg == M_NUM || mode_reg == M_NUM_ZERO)
                begin
                    p1 = 1'b1; l1 = len_pend;
                    k1 = num_bad ? K_ERROR : K_INT; e1 = num_bad ? E_INT : E_NONE;
                    ecount = {1'b0, num_bad};
                end
                else if (mode_reg == M_SLASH)
                begin
                    p1 = 1'b1; k1 = K_SLASH; l1 = OFFSET_BITS'(1);
                end
                else if (mode_reg >= M_MINUS)
                begin
                    p1 = 1'b1; k1 = op_one; l1 = OFFSET_BITS'(1);
                end
                else if (mode_reg == M_BLOCK || mode_reg == M_BLOCK_STAR)
                begin
                    e2 = E_BLOCK; ecount = 2'd1;
                end
                else
                begin
                    // idle or line comment: nothing is pending
                end
                p2 = 1'b1; k2 = K_EOF; fin2 = 1'b1;
                mode_next = M_IDLE; crp_next = 1'b0; closed_next = 1'b1;
            end
            else if (crp_reg && b == CH_LF)
            begin
                crp_next = 1'b0; pos_next = pos_inc;
            end
            else
            begin
                crp_next = 1'b0;
                do_start = 1'b1; do_move = 1'b1;
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        if (is_cont)
                        begin
                            kw_next = {kw_reg[39:0], b};
                            if (wl_reg != 3'd7) wl_next = wl_reg + 3'd1;
                            do_start = 1'b0;
                        end
                        else
                        begin
                            p1 = 1'b1; k1 = wk; l1 = len_pend;
                        end
                    end
                    M_NUM_ZERO, M_NUM:
                    begin
                        if (mode_reg == M_NUM_ZERO &&
                            (b == "x" || b == "X" || b == "b" || b == "B"))
                        begin
                            base_next = (b == "x" || b == "X") ? B_HEX : B_BIN;
                            fl_next = 3'd0; mode_next = M_NUM; do_start = 1'b0;
                        end
                        else if (is_cont)
                        begin
                            if (b == "_")
                                fl_next = {fl_reg[2] | !fl_reg[0] | fl_reg[1], 1'b1, fl_reg[0]};
                            else
                                fl_next = {fl_reg[2] | is_bad_digit, 1'b0, 1'b1};
                            mode_next = M_NUM; do_start = 1'b0;
                        end
                        else
                        begin
                            p1 = 1'b1; l1 = len_pend;
                            k1 = num_bad ? K_ERROR : K_INT; e1 = num_bad ? E_INT : E_NONE;
                            ecount = {1'b0, num_bad};
                        end
                    end
                    M_SLASH:
                    begin
                        if (b == "/" || b == "*")
                        begin
                            mode_next = (b == "/") ? M_LINE : M_BLOCK; do_start = 1'b0;
                        end
                        else
                        begin
                            p1 = 1'b1; k1 = K_SLASH; l1 = OFFSET_BITS'(1);
                        end
                    end
                    M_LINE:
                    begin
                        if (!is_brk) do_start = 1'b0;
                    end
                    M_BLOCK, M_BLOCK_STAR:
                    begin
                        if (mode_reg == M_BLOCK_STAR && b == "/") mode_next = M_IDLE;
                        else mode_next = (b == "*") ? M_BLOCK_STAR : M_BLOCK;
                        do_start = 1'b0;
                    end
                    M_MINUS, M_BANG, M_ASSIGN, M_LESS, M_GREATER:
                    begin
                        p1 = 1'b1; k1 = (b == op_second) ? op_two : op_one;
                        l1 = (b == op_second) ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
                        if (b == op_second)
                        begin
                            mode_next = M_IDLE; do_start = 1'b0;
                        end
                    end
                    default: ;
                endcase
                if (do_start)
                begin
                    mode_next = M_IDLE;
                    tsp_next = pos_reg; tsl_next = line_reg; tsc_next = col_reg;
                    if (b == " " || b == 8'h09 || is_brk)
                    begin
                    end
                    else if (is_start)
                    begin
                        mode_next = M_IDENT; kw_next = {40'd0, b}; wl_next = 3'd1;
                    end
                    else if (is_digit)
                    begin
                        mode_next = (b == "0") ? M_NUM_ZERO : M_NUM;
                        base_next = B_DEC; fl_next = 3'd1;
                    end
                    else
                    begin
                        unique case (b)
                            "/": mode_next = M_SLASH;
                            "-": mode_next = M_MINUS;
                            "!": mode_next = M_BANG;
                            "=": mode_next = M_ASSIGN;
                            "<": mode_next = M_LESS;
                            ">": mode_next = M_GREATER;
                            default:
                            begin
                                p2 = 1'b1; k2 = one_kind; l2 = OFFSET_BITS'(1);
                                if (one_kind == K_ERROR)
                                begin
                                    e2 = E_CHAR; ecount = ecount + 2'd1;
                                end
                            end
                        endcase
                    end
                end
                if (do_move)
                begin
                    pos_next = pos_inc;
                    if (is_brk)
                    begin
                        line_next = line_inc; col_next = LINE_BITS'(1);
                        if (b == CH_CR) crp_next = 1'b1;
                    end
                    else col_next = col_inc;
                end
            end
        end
        et1 = (p1 && e1 != E_NONE && et_reg != 16'hFFFF) ? et_reg + 16'd1 : et_reg;
        et2 = (ecount != 2'd0 && et1 != 16'hFFFF && e2 != E_NONE) ? et1 + 16'd1 : et1;
    end

    // the pending token takes its saved start; a token from this byte takes the current position
    always_comb
    begin
        res.n1 = p1;
        res.n2 = p2;
        res.t1.kind = k1; res.t1.len = l1; res.t1.err = e1; res.t1.errs = et1;
        res.t1.fin = 1'b0;
        res.t1.start = tsp_reg; res.t1.line = tsl_reg; res.t1.col = tsc_reg;
        res.t2.kind = k2; res.t2.len = l2; res.t2.err = e2; res.t2.errs = et2;
        res.t2.fin = fin2;
        res.t2.start = pos_reg;
        res.t2.line = line_reg; res.t2.col = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; crp_reg <= 1'b0; kw_reg <= '0; wl_reg <= '0;
            base_reg <= B_DEC; fl_reg <= '0; pos_reg <= '0; line_reg <= LINE_BITS'(1);
            col_reg <= LINE_BITS'(1); tsp_reg <= '0; tsl_reg <= LINE_BITS'(1);
            tsc_reg <= LINE_BITS'(1);
            et_reg <= '0; closed_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next; crp_reg <= crp_next; kw_reg <= kw_next;
            wl_reg <= wl_next; base_reg <= base_next; fl_reg <= fl_next;
            pos_reg <= pos_next; line_reg <= line_next; col_reg <= col_next;
            tsp_reg <= tsp_next; tsl_reg <= tsl_next; tsc_reg <= tsc_next;
            et_reg <= et2; closed_reg <= closed_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) closed_reg |=> closed_reg)
        else $error("stream reopened");
    assert property (@(posedge clk) disable iff (!rst_n) closed_reg |-> mode_reg == M_IDLE)
        else $error("mode active after close");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(closed_reg) |-> $stable(et_reg))
        else $error("error count moved after close");

endmodule

`default_nettype wire

// ----- sv/stok_outq.sv -----
// ============================================================================
// Tokenizer result queue
// Four-entry queue of tokens; one or two written per cycle, one read.
// ============================================================================
`default_nettype none

module stok_outq
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stok_pkg::result_t   res,
    output logic                     room,
    output logic                     valid,
    input  wire logic                take,
    output stok_pkg::token_t         head
);
    import stok_pkg::*;

    token_t     q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] nw;
    logic       tk;

    always_comb
    begin
        nw = {1'b0, res.n1} + {1'b0, res.n2};
        tk = take && cnt_reg != 3'd0;
        valid = cnt_reg != 3'd0;
        head = q_reg[rd_reg];
        room = cnt_reg <= 3'd2;
    end

    always_ff @(posedge clk)
    begin
        if (res.n1) q_reg[wr_reg] <= res.t1;
        if (res.n2) q_reg[res.n1 ? wr_reg + 2'd1 : wr_reg] <= res.t2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_reg + nw;
            rd_reg <= rd_reg + {1'b0, tk};
            cnt_reg <= cnt_reg + {1'b0, nw} - {2'b0, tk};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !room |-> nw == 2'd0)
        else $error("write without room");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !take) |=> valid)
        else $error("token lost");

endmodule

`default_nettype wire
